@@ src/eps2d_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the epoch-seconds to calendar date converter.
// No dependencies; imported by eps2d_tod and epoch_seconds_to_date_core.
package eps2d_pkg;

    // First count of 2100-01-01 00:00:00 (36525 days)
    localparam logic [31:0] LIMIT_SECONDS = 32'hBC191380;

    // Seconds per day is 128 * 675; the day split divides the count >> 7 by 675
    localparam logic [9:0]  DAY_DIV    = 10'd675;
    localparam logic [25:0] DAY_RECIP  = 26'd50903316;   // floor(2^35 / 675)
    localparam int          DAY_SHIFT  = 35;

    // Four-year cycle of 1461 days, starting with a leap year
    localparam logic [10:0] CYCLE_DAYS  = 11'd1461;
    localparam logic [15:0] CYCLE_RECIP = 16'd45933;     // floor(2^26 / 1461)
    localparam int          CYCLE_SHIFT = 26;

    // Day-of-cycle boundaries of the second, third and fourth year
    localparam logic [10:0] YEAR1_START = 11'd366;
    localparam logic [10:0] YEAR2_START = 11'd731;
    localparam logic [10:0] YEAR3_START = 11'd1096;

    // Time of day constants
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [10:0] HOUR_RECIP    = 11'd1165;    // floor(2^22 / 3600)
    localparam int          HOUR_SHIFT    = 22;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [10:0] MIN_RECIP     = 11'd1092;    // floor(2^16 / 60)
    localparam int          MIN_SHIFT     = 16;

    // Days before the first of each month in a common year
    localparam logic [8:0] CUM_DAYS [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // Time-of-day result handed from the time path to the output stage
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } tod_t;

endpackage

@@ src/eps2d_tod.sv @@
`timescale 1ns / 1ps
// Time-of-day path: splits the seconds within a day into hour, minute, second.
// Depends on eps2d_pkg; five register stages that advance on the shared enable.
module eps2d_tod (
    input  logic              aclk,
    input  logic              en,
    input  logic [16:0]       rem,
    output eps2d_pkg::tod_t   tod
);
    import eps2d_pkg::*;

    // Stage A: hour estimate product
    logic [26:0] prodh_reg;
    logic [16:0] rema_reg;
    // Stage B: hour estimate times 3600
    logic [4:0]  hestb_reg;
    logic [16:0] phb_reg;
    logic [16:0] remb_reg;
    // Stage C: corrected hour and seconds within hour
    logic [4:0]  hourc_reg;
    logic [11:0] rhc_reg;
    // Stage D: minute estimate product
    logic [4:0]  hourd_reg;
    logic [11:0] rhd_reg;
    logic [21:0] prodm_reg;
    // Stage E: minute estimate times 60
    logic [4:0]  houre_reg;
    logic [11:0] rhe_reg;
    logic [5:0]  meste_reg;
    logic [11:0] pme_reg;

    logic [4:0]  hest;
    logic [12:0] rh_raw;
    logic [4:0]  hour_next;
    logic [11:0] rh_next;
    logic [5:0]  mest;
    logic [6:0]  rs_raw;

    // Correct the hour estimate by at most one
    always_comb begin
        hest   = prodh_reg[HOUR_SHIFT +: 5];
        rh_raw = 13'(remb_reg - phb_reg);
        if (rh_raw >= 13'(SECS_PER_HOUR)) begin
            hour_next = hestb_reg + 5'd1;
            rh_next   = 12'(rh_raw - 13'(SECS_PER_HOUR));
        end else begin
            hour_next = hestb_reg;
            rh_next   = rh_raw[11:0];
        end
    end

    assign mest = prodm_reg[MIN_SHIFT +: 6];

    // Advance all stages together
    always_ff @(posedge aclk) begin
        if (en) begin
            prodh_reg <= 27'(rem) * 27'(HOUR_RECIP);
            rema_reg  <= rem;
            hestb_reg <= hest;
            phb_reg   <= 17'(hest) * 17'(SECS_PER_HOUR);
            remb_reg  <= rema_reg;
            hourc_reg <= hour_next;
            rhc_reg   <= rh_next;
            hourd_reg <= hourc_reg;
            rhd_reg   <= rhc_reg;
            prodm_reg <= 22'(rhc_reg) * 22'(MIN_RECIP);
            houre_reg <= hourd_reg;
            rhe_reg   <= rhd_reg;
            meste_reg <= mest;
            pme_reg   <= 12'(mest) * 12'(SECS_PER_MIN);
        end
    end

    // Correct the minute estimate by at most one
    always_comb begin
        rs_raw   = 7'(rhe_reg - pme_reg);
        tod.hour = houre_reg;
        if (rs_raw >= 7'(SECS_PER_MIN)) begin
            tod.minute = meste_reg + 6'd1;
            tod.second = 6'(rs_raw - 7'(SECS_PER_MIN));
        end else begin
            tod.minute = meste_reg;
            tod.second = rs_raw[5:0];
        end
    end

endmodule

@@ src/epoch_seconds_to_date_core.sv @@
`timescale 1ns / 1ps
// Top level: seconds since 2000-01-01 00:00:00 to calendar date and time of day.
// Depends on eps2d_pkg and eps2d_tod.
//
//   channel | dir | tdata (low bit up)                                  | tuser
//   s_      | in  | seconds[31:0]                                       | -
//   m_      | out | year[6:0] month[10:7] day[15:11] hour[20:16]        | out_of_range[0]
//           |     | minute[26:21] second[32:27], zeros to bit 39         |
//
// One transfer per cycle in, one result per cycle out while the output is not stalled;
// each result passes through the stage registers and then the output register, a chain
// of reciprocal multiplies (day split, cycle split, hour and minute splits) with a correction after each.
// All stages advance together while the output register is empty or taken; a
// stall holds every stage. Reset clears only the valid bits.
module epoch_seconds_to_date_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // seconds[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // year, month, day, hour, minute, second
    output logic [0:0]  m_tuser    // out_of_range
);
    import eps2d_pkg::*;

    logic        en;
    logic [8:1]  valid_reg;
    logic        m_tvalid_reg;

    // Stage 1: day product
    logic        oor1_reg;
    logic [24:0] q1_reg;
    logic [6:0]  lo1_reg;
    logic [50:0] prod1_reg;
    // Stage 2: day estimate times 675
    logic        oor2_reg;
    logic [24:0] q2_reg;
    logic [6:0]  lo2_reg;
    logic [15:0] est2_reg;
    logic [24:0] p2_reg;
    // Stage 3: day count and seconds within day
    logic        oor3_reg;
    logic [15:0] days3_reg;
    logic [16:0] rem3_reg;
    // Stage 4: cycle product
    logic        oor4_reg;
    logic [15:0] days4_reg;
    logic [31:0] prod4_reg;
    // Stage 5: cycle estimate times 1461
    logic        oor5_reg;
    logic [15:0] days5_reg;
    logic [5:0]  cyc5_reg;
    logic [15:0] pc5_reg;
    // Stage 6: corrected cycle and day of cycle
    logic        oor6_reg;
    logic [5:0]  cyc6_reg;
    logic [10:0] dc6_reg;
    // Stage 7: year, day of year, leap
    logic        oor7_reg;
    logic [6:0]  year7_reg;
    logic [8:0]  doy7_reg;
    logic        leap7_reg;
    // Stage 8: month and its start
    logic        oor8_reg;
    logic [6:0]  year8_reg;
    logic [3:0]  mon8_reg;
    logic [8:0]  dnum8_reg;
    logic [8:0]  base8_reg;
    // Output register
    logic        oor_reg;
    logic [6:0]  year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;

    logic [10:0] r3_raw;
    logic [15:0] days_next;
    logic [9:0]  r3_next;
    logic [5:0]  cyc5_next;
    logic [11:0] dc_raw;
    logic [5:0]  cyc_next;
    logic [10:0] dc_next;
    logic [1:0]  yoff;
    logic [8:0]  doy_next;
    logic        leap_next;
    logic [8:0]  dnum;
    logic [3:0]  mon_next;
    logic [8:0]  base_next;
    logic [4:0]  day_next;
    tod_t        tod;

    // Whole pipeline moves when the output register can take a result
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            valid_reg    <= {valid_reg[7:1], s_tvalid};
            m_tvalid_reg <= valid_reg[8];
        end
    end

    // Correct the day estimate and form the seconds within the day
    always_comb begin
        r3_raw = 11'(q2_reg - p2_reg);
        if (r3_raw >= 11'(DAY_DIV)) begin
            days_next = est2_reg + 16'd1;
            r3_next   = 10'(r3_raw - 11'(DAY_DIV));
        end else begin
            days_next = est2_reg;
            r3_next   = r3_raw[9:0];
        end
    end

    assign cyc5_next = prod4_reg[CYCLE_SHIFT +: 6];

    // Correct the cycle estimate
    always_comb begin
        dc_raw = 12'(days5_reg - pc5_reg);
        if (dc_raw >= 12'(CYCLE_DAYS)) begin
            cyc_next = cyc5_reg + 6'd1;
            dc_next  = 11'(dc_raw - 12'(CYCLE_DAYS));
        end else begin
            cyc_next = cyc5_reg;
            dc_next  = dc_raw[10:0];
        end
    end

    // Place the day within its four-year cycle
    always_comb begin
        if (dc6_reg < YEAR1_START) begin
            yoff      = 2'd0;
            doy_next  = dc6_reg[8:0];
            leap_next = 1'b1;
        end else if (dc6_reg < YEAR2_START) begin
            yoff      = 2'd1;
            doy_next  = 9'(dc6_reg - YEAR1_START);
            leap_next = 1'b0;
        end else if (dc6_reg < YEAR3_START) begin
            yoff      = 2'd2;
            doy_next  = 9'(dc6_reg - YEAR2_START);
            leap_next = 1'b0;
        end else begin
            yoff      = 2'd3;
            doy_next  = 9'(dc6_reg - YEAR3_START);
            leap_next = 1'b0;
        end
    end

    // Find the month: the last start that lies below the day number
    always_comb begin
        logic [8:0] cand;
        dnum      = doy7_reg + 9'd1;
        mon_next  = 4'd1;
        base_next = 9'd0;
        for (int i = 1; i < 12; i++) begin
            cand = CUM_DAYS[4'(i)] + ((i >= 2) ? {8'd0, leap7_reg} : 9'd0);
            if (dnum > cand) begin
                mon_next  = 4'(i + 1);
                base_next = cand;
            end
        end
    end

    assign day_next = 5'(dnum8_reg - base8_reg);

    // Date path registers
    always_ff @(posedge aclk) begin
        if (en) begin
            oor1_reg   <= (s_tdata >= LIMIT_SECONDS);
            q1_reg     <= s_tdata[31:7];
            lo1_reg    <= s_tdata[6:0];
            prod1_reg  <= 51'(s_tdata[31:7]) * 51'(DAY_RECIP);

            oor2_reg   <= oor1_reg;
            q2_reg     <= q1_reg;
            lo2_reg    <= lo1_reg;
            est2_reg   <= prod1_reg[DAY_SHIFT +: 16];
            p2_reg     <= 25'(prod1_reg[DAY_SHIFT +: 16]) * 25'(DAY_DIV);

            oor3_reg   <= oor2_reg;
            days3_reg  <= days_next;
            rem3_reg   <= {r3_next, lo2_reg};

            oor4_reg   <= oor3_reg;
            days4_reg  <= days3_reg;
            prod4_reg  <= 32'(days3_reg) * 32'(CYCLE_RECIP);

            oor5_reg   <= oor4_reg;
            days5_reg  <= days4_reg;
            cyc5_reg   <= cyc5_next;
            pc5_reg    <= 16'(cyc5_next) * 16'(CYCLE_DAYS);

            oor6_reg   <= oor5_reg;
            cyc6_reg   <= cyc_next;
            dc6_reg    <= dc_next;

            oor7_reg   <= oor6_reg;
            year7_reg  <= 7'({cyc6_reg, 2'b00} + 8'(yoff));
            doy7_reg   <= doy_next;
            leap7_reg  <= leap_next;

            oor8_reg   <= oor7_reg;
            year8_reg  <= year7_reg;
            mon8_reg   <= mon_next;
            dnum8_reg  <= dnum;
            base8_reg  <= base_next;

            // Replace the result with the default date beyond 2099
            oor_reg    <= oor8_reg;
            year_reg   <= oor8_reg ? 7'd0 : year8_reg;
            month_reg  <= oor8_reg ? 4'd1 : mon8_reg;
            day_reg    <= oor8_reg ? 5'd1 : day_next;
            hour_reg   <= oor8_reg ? 5'd0 : tod.hour;
            minute_reg <= oor8_reg ? 6'd0 : tod.minute;
            second_reg <= oor8_reg ? 6'd0 : tod.second;
        end
    end

    // Time-of-day path, aligned to stages 4 through 8
    eps2d_tod u_tod (
        .aclk (aclk),
        .en   (en),
        .rem  (rem3_reg),
        .tod  (tod)
    );

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {7'd0, second_reg, minute_reg, hour_reg, day_reg, month_reg, year_reg};
    assign m_tuser[0] = oor_reg;

    // Out-of-range results carry the default date
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && oor_reg |-> year_reg == 7'd0 && month_reg == 4'd1 && day_reg == 5'd1
            && hour_reg == 5'd0 && minute_reg == 6'd0 && second_reg == 6'd0)
        else $error("out-of-range result without default date");

    // In-range results are legal calendar values
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !oor_reg |-> year_reg <= 7'd99 && month_reg >= 4'd1
            && month_reg <= 4'd12 && day_reg >= 5'd1 && hour_reg <= 5'd23
            && minute_reg <= 6'd59 && second_reg <= 6'd59)
        else $error("result field out of calendar range");

    // A stall at the input only comes from a held result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // An accepted transfer enters the first stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> valid_reg[1])
        else $error("accepted transfer lost at stage 1");

    // A held pipeline keeps the output result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule
